/* rtl/fmbs_pkg.sv */
package fmbs_pkg;

   localparam int MAX_BASES_DEF   = 1048576;
   localparam int BLOCK_BASES_DEF = 16;
   localparam int MAX_PATTERN_DEF = 1024;

   localparam int CNT_W     = 21;
   localparam int ML_W      = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_BWT_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SENTINEL_POS = 2'd1;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_LOAD_END = 7'b0000010,
      ST_RK_IDX   = 7'b0000100,
      ST_RK_RD    = 7'b0001000,
      ST_RK_ACC   = 7'b0010000,
      ST_RK_DONE  = 7'b0100000,
      ST_RESULT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic load_end;
      logic init;
      logic stop;
      logic step;
      logic rk_idx;
      logic issue;
      logic rk_done;
      logic sel;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic stopped;
      logic k_last;
   } stat_type;

endpackage

/* rtl/fmbs_if.sv */
interface fmbs_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] packed_byte;
   logic [1:0] symbol;
   logic       is_first;
   logic       is_last;
   modport source (output valid, func, packed_byte, symbol, is_first, is_last, input ready);
   modport sink (input valid, func, packed_byte, symbol, is_first, is_last, output ready);
endinterface

interface fmbs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fmbs_pkg::ML_W-1:0]   match_length;
   logic [fmbs_pkg::CNT_W-1:0]  range_start;
   logic [fmbs_pkg::CNT_W-1:0]  range_end;
   logic [fmbs_pkg::CNT_W-1:0]  final_start;
   logic [fmbs_pkg::CNT_W-1:0]  final_end;
   logic                        full_match;
   modport source (output valid, match_length, range_start, range_end, final_start,
                   final_end, full_match, input ready);
   modport sink (input valid, match_length, range_start, range_end, final_start,
                 final_end, full_match, output ready);
endinterface

interface fmbs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fmbs_pkg::CSR_IDX_W-1:0]   index;
   logic [fmbs_pkg::CNT_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/fmbs_ram.sv */
module fmbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/fmbs_ctrl.sv */
module fmbs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic               req_first,
   input  logic               req_last,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  fmbs_pkg::stat_type stat,
   output fmbs_pkg::cmd_type  cmd
);

   fmbs_pkg::state_type state_ff, state_in;
   logic sel_ff, sel_in;
   logic last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == fmbs_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      sel_in   = sel_ff;
      last_in  = last_ff;
      case (state_ff)
         fmbs_pkg::ST_IDLE: begin
            if (accept) begin
               last_in = req_last;
               if (req_func == fmbs_pkg::FUNC_LOAD) begin
                  cmd.load = 1'b1;
                  if (req_last) state_in = fmbs_pkg::ST_LOAD_END;
               end else if (req_first) begin
                  cmd.init = 1'b1;
                  if (req_last) state_in = fmbs_pkg::ST_RESULT;
               end else if (stat.stopped || stat.empty) begin
                  cmd.stop = 1'b1;
                  if (req_last) state_in = fmbs_pkg::ST_RESULT;
               end else begin
                  cmd.step = 1'b1;
                  sel_in   = 1'b0;
                  state_in = fmbs_pkg::ST_RK_IDX;
               end
            end
         end
         fmbs_pkg::ST_LOAD_END: begin
            cmd.load_end = 1'b1;
            state_in     = fmbs_pkg::ST_IDLE;
         end
         fmbs_pkg::ST_RK_IDX: begin
            cmd.rk_idx = 1'b1;
            cmd.sel    = sel_ff;
            state_in   = fmbs_pkg::ST_RK_RD;
         end
         fmbs_pkg::ST_RK_RD: begin
            cmd.issue = 1'b1;
            if (stat.k_last) state_in = fmbs_pkg::ST_RK_ACC;
         end
         fmbs_pkg::ST_RK_ACC: begin
            // The last byte read lands in the accumulator during this cycle.
            state_in = fmbs_pkg::ST_RK_DONE;
         end
         fmbs_pkg::ST_RK_DONE: begin
            cmd.rk_done = 1'b1;
            cmd.sel     = sel_ff;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = fmbs_pkg::ST_RK_IDX;
            end else if (last_ff) begin
               state_in = fmbs_pkg::ST_RESULT;
            end else begin
               state_in = fmbs_pkg::ST_IDLE;
            end
         end
         fmbs_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = fmbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fmbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmbs_pkg::ST_IDLE;
         sel_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/fmbs_dpath.sv */
module fmbs_dpath #(
   parameter int MAX_BASES   = fmbs_pkg::MAX_BASES_DEF,
   parameter int BLOCK_BASES = fmbs_pkg::BLOCK_BASES_DEF,
   parameter int MAX_PATTERN = fmbs_pkg::MAX_PATTERN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fmbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fmbs_pkg::CNT_W-1:0]       csr_data,
   input  logic [7:0]                       req_packed_byte,
   input  logic [1:0]                       req_symbol,
   input  fmbs_pkg::cmd_type                cmd,
   output fmbs_pkg::stat_type               stat,
   output logic [fmbs_pkg::ML_W-1:0]        rsp_match_length,
   output logic [fmbs_pkg::CNT_W-1:0]       rsp_range_start,
   output logic [fmbs_pkg::CNT_W-1:0]       rsp_range_end,
   output logic [fmbs_pkg::CNT_W-1:0]       rsp_final_start,
   output logic [fmbs_pkg::CNT_W-1:0]       rsp_final_end,
   output logic                             rsp_full_match
);

   localparam int CW_CNT      = fmbs_pkg::CNT_W;
   localparam int BLOCK_BYTES = BLOCK_BASES / 4;
   localparam int STORE_BYTES = MAX_BASES / 4;
   localparam int CK_ROWS     = MAX_BASES / BLOCK_BASES + 1;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int CAW         = $clog2(CK_ROWS);
   localparam int LP_W        = $clog2(STORE_BYTES + 1);
   localparam int KW          = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int OFF_W       = $clog2(BLOCK_BASES);
   localparam int PW          = (KW + 2 > OFF_W) ? KW + 2 : OFF_W;
   localparam int CW          = (LP_W + 2 > CW_CNT) ? LP_W + 2 : CW_CNT;
   localparam int MC_W        = $clog2(MAX_PATTERN + 1);
   localparam int CKW         = 4 * CW_CNT;

   logic [CW_CNT-1:0] len_ff, len_in, sent_ff, sent_in, len_eff;
   logic [CW_CNT-1:0] rc_ff [4];
   logic [CW_CNT-1:0] rc_in [4];
   logic [CW_CNT-1:0] rc_new [4];
   logic [CW_CNT-1:0] offs_ff [5];
   logic [CW_CNT-1:0] offs_in [5];
   logic [LP_W-1:0]   lp_ff, lp_in, lp_nxt;
   logic [CW_CNT-1:0] cur_s_ff, cur_s_in, cur_e_ff, cur_e_in;
   logic [CW_CNT-1:0] prv_s_ff, prv_s_in, prv_e_ff, prv_e_in;
   logic [MC_W-1:0]   mc_ff, mc_in;
   logic              stop_ff, stop_in;
   logic [1:0]        sym_ff, sym_in;
   logic [CW_CNT-1:0] idx_ff, idx_in;
   logic [KW-1:0]     k_ff, k_in, rd_k_ff;
   logic              rd_v_ff;
   logic [CW_CNT-1:0] acc_ff, acc_in;
   logic [CW_CNT-1:0] operand, idx_adj, rank_base, rank_res;
   logic [OFF_W-1:0]  off;
   logic [2:0]        cnt;
   logic [2:0]        bc [4];
   logic              ld_ok, ckz;

   logic              bwt_we, ck_we;
   logic [AW-1:0]     bwt_waddr, bwt_raddr;
   logic [CAW-1:0]    ck_waddr, ck_raddr;
   logic [7:0]        bwt_rdata;
   logic [CKW-1:0]    ck_wdata, ck_rdata;

   logic [fmbs_pkg::ML_W-1:0] ml_ff, ml_in;
   logic [CW_CNT-1:0] rs_ff, rs_in, re_ff, re_in, fs_ff, fe_ff;
   logic              full_ff, full_in;

   assign len_eff = ({11'd0, len_ff} < 32'(MAX_BASES)) ? len_ff : CW_CNT'(MAX_BASES);

   always_comb begin
      len_in  = len_ff;
      sent_in = sent_ff;
      if (csr_we) begin
         case (csr_index)
            fmbs_pkg::REG_BWT_LENGTH:   len_in  = csr_data;
            fmbs_pkg::REG_SENTINEL_POS: sent_in = csr_data;
            default: ;
         endcase
      end
   end

   // Loader: per-symbol counts of the bases of this byte that lie inside the BWT.
   always_comb begin
      ld_ok = CW'({lp_ff, 2'b00}) < CW'(len_eff);
      for (int s = 0; s < 4; s++) begin
         bc[s] = 3'd0;
         for (int j = 0; j < 4; j++) begin
            if (req_packed_byte[7-2*j -: 2] == 2'(s) &&
                CW'({lp_ff, 2'(j)}) < CW'(len_eff)) begin
               bc[s] = bc[s] + 3'd1;
            end
         end
         rc_new[s] = rc_ff[s] + CW_CNT'(bc[s]);
      end
      lp_nxt = lp_ff + LP_W'(1);
   end

   assign bwt_we    = cmd.load && ld_ok;
   assign bwt_waddr = AW'(lp_ff);
   assign ck_we     = cmd.load && ld_ok && ((lp_nxt % BLOCK_BYTES) == 0);
   assign ck_waddr  = CAW'(lp_nxt / BLOCK_BYTES);
   assign ck_wdata  = {rc_new[3], rc_new[2], rc_new[1], rc_new[0]};

   // Rank: checkpoint row plus a byte-serial count over the block.
   assign ck_raddr  = CAW'(idx_ff / BLOCK_BASES);
   assign bwt_raddr = AW'((idx_ff / BLOCK_BASES) * BLOCK_BYTES + k_ff);
   assign off       = OFF_W'(idx_ff % BLOCK_BASES);
   assign ckz       = (idx_ff / BLOCK_BASES) == 0;
   assign rank_base = ckz ? '0 : ck_rdata[sym_ff*CW_CNT +: CW_CNT];
   assign operand   = cmd.sel ? prv_e_ff : prv_s_ff;
   assign rank_res  = offs_ff[sym_ff] + acc_ff;

   always_comb begin
      idx_adj = (operand > sent_ff) ? operand - CW_CNT'(1) : operand;
      if (idx_adj > len_eff) idx_adj = len_eff;
      cnt = 3'd0;
      for (int j = 0; j < 4; j++) begin
         if (bwt_rdata[7-2*j -: 2] == sym_ff && PW'({rd_k_ff, 2'(j)}) < PW'(off)) begin
            cnt = cnt + 3'd1;
         end
      end
   end

   always_comb begin
      rc_in    = rc_ff;
      offs_in  = offs_ff;
      lp_in    = lp_ff;
      cur_s_in = cur_s_ff;
      cur_e_in = cur_e_ff;
      prv_s_in = prv_s_ff;
      prv_e_in = prv_e_ff;
      mc_in    = mc_ff;
      stop_in  = stop_ff;
      sym_in   = sym_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      if (bwt_we) begin
         rc_in = rc_new;
         lp_in = lp_nxt;
      end
      if (cmd.load_end) begin
         offs_in[0] = CW_CNT'(1);
         for (int s = 0; s < 4; s++) begin
            offs_in[s+1] = offs_in[s] + rc_ff[s];
            rc_in[s]     = '0;
         end
         lp_in = '0;
      end
      if (cmd.init) begin
         cur_s_in = offs_ff[req_symbol];
         cur_e_in = offs_ff[3'(req_symbol) + 3'd1];
         prv_s_in = '0;
         prv_e_in = '0;
         mc_in    = MC_W'(1);
         stop_in  = 1'b0;
      end
      if (cmd.stop) stop_in = 1'b1;
      if (cmd.step) begin
         prv_s_in = cur_s_ff;
         prv_e_in = cur_e_ff;
         sym_in   = req_symbol;
         if (mc_ff < MC_W'(MAX_PATTERN)) mc_in = mc_ff + MC_W'(1);
      end
      if (cmd.rk_idx) begin
         idx_in = idx_adj;
         k_in   = '0;
      end else if (cmd.issue) begin
         k_in = k_ff + KW'(1);
      end
      if (rd_v_ff) begin
         acc_in = ((rd_k_ff == '0) ? rank_base : acc_ff) + CW_CNT'(cnt);
      end
      if (cmd.rk_done) begin
         if (cmd.sel) cur_e_in = rank_res;
         else cur_s_in = rank_res;
      end
   end

   always_comb begin
      if (cur_e_ff <= cur_s_ff) begin
         ml_in   = fmbs_pkg::ML_W'((mc_ff > '0) ? mc_ff - MC_W'(1) : '0);
         rs_in   = prv_s_ff;
         re_in   = prv_e_ff;
         full_in = 1'b0;
      end else begin
         ml_in   = fmbs_pkg::ML_W'(mc_ff);
         rs_in   = cur_s_ff;
         re_in   = cur_e_ff;
         full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= CW_CNT'(1);
         sent_ff  <= '0;
         rc_ff    <= '{default: '0};
         offs_ff  <= '{default: '0};
         lp_ff    <= '0;
         cur_s_ff <= '0;
         cur_e_ff <= '0;
         prv_s_ff <= '0;
         prv_e_ff <= '0;
         mc_ff    <= '0;
         stop_ff  <= 1'b0;
         k_ff     <= '0;
         rd_v_ff  <= 1'b0;
      end else begin
         len_ff   <= len_in;
         sent_ff  <= sent_in;
         rc_ff    <= rc_in;
         offs_ff  <= offs_in;
         lp_ff    <= lp_in;
         cur_s_ff <= cur_s_in;
         cur_e_ff <= cur_e_in;
         prv_s_ff <= prv_s_in;
         prv_e_ff <= prv_e_in;
         mc_ff    <= mc_in;
         stop_ff  <= stop_in;
         k_ff     <= k_in;
         rd_v_ff  <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      rd_k_ff <= k_ff;
      if (cmd.out_load) begin
         ml_ff   <= ml_in;
         rs_ff   <= rs_in;
         re_ff   <= re_in;
         fs_ff   <= cur_s_ff;
         fe_ff   <= cur_e_ff;
         full_ff <= full_in;
      end
   end

   fmbs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_bwt_ram (
      .clock (clock),
      .we    (bwt_we),
      .waddr (bwt_waddr),
      .wdata (req_packed_byte),
      .raddr (bwt_raddr),
      .rdata (bwt_rdata)
   );

   fmbs_ram #(.WIDTH(CKW), .DEPTH(CK_ROWS)) u_ckpt_ram (
      .clock (clock),
      .we    (ck_we),
      .waddr (ck_waddr),
      .wdata (ck_wdata),
      .raddr (ck_raddr),
      .rdata (ck_rdata)
   );

   assign stat.empty   = cur_e_ff <= cur_s_ff;
   assign stat.stopped = stop_ff;
   assign stat.k_last  = k_ff == KW'(BLOCK_BYTES - 1);

   assign rsp_match_length = ml_ff;
   assign rsp_range_start  = rs_ff;
   assign rsp_range_end    = re_ff;
   assign rsp_final_start  = fs_ff;
   assign rsp_final_end    = fe_ff;
   assign rsp_full_match   = full_ff;

endmodule

/* rtl/fm_index_backward_search.sv */
// FM-index backward search over a 2-bit packed DNA BWT. Load transactions store
// one BWT byte each (the byte marked last also passes through a load-end state
// that forms the symbol offsets). A pattern symbol that starts a search, or arrives
// after the range went empty, needs no rank lookup; any other symbol runs the
// two rank lookups, each of which reads one checkpoint row and then counts the
// block's BWT bytes one per cycle through the single read port of the BWT memory.
// A result sits in an output register, so the next transaction is taken while it
// waits. The BWT and checkpoint memories need no clearing.
module fm_index_backward_search #(
   parameter int MAX_BASES   = fmbs_pkg::MAX_BASES_DEF,
   parameter int BLOCK_BASES = fmbs_pkg::BLOCK_BASES_DEF,
   parameter int MAX_PATTERN = fmbs_pkg::MAX_PATTERN_DEF
) (
   input logic        clock,
   input logic        reset,
   fmbs_req_if.sink   req_chan,
   fmbs_rsp_if.source rsp_chan,
   fmbs_csr_if.sink   csr_chan
);

   fmbs_pkg::cmd_type  cmd;
   fmbs_pkg::stat_type stat;

   assign csr_chan.ready = 1'b1;

   fmbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_func  (req_chan.func),
      .req_first (req_chan.is_first),
      .req_last  (req_chan.is_last),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   fmbs_dpath #(
      .MAX_BASES   (MAX_BASES),
      .BLOCK_BASES (BLOCK_BASES),
      .MAX_PATTERN (MAX_PATTERN)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .req_packed_byte  (req_chan.packed_byte),
      .req_symbol       (req_chan.symbol),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_match_length (rsp_chan.match_length),
      .rsp_range_start  (rsp_chan.range_start),
      .rsp_range_end    (rsp_chan.range_end),
      .rsp_final_start  (rsp_chan.final_start),
      .rsp_final_end    (rsp_chan.final_end),
      .rsp_full_match   (rsp_chan.full_match)
   );

   // A new result must never overwrite one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten");

   // Starting a search always rearms the matcher.
   a_init_rearms: assert property (@(posedge clock) disable iff (reset)
      cmd.init |=> !stat.stopped)
      else $error("search start left the matcher stopped");

   // No transaction is taken while a rank lookup is reading memory.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !(req_chan.valid && req_chan.ready))
      else $error("transaction accepted during rank lookup");

endmodule

/* bench/fmbs_search_checker.sv */
module fmbs_search_checker (
   input  logic clock,
   input  logic reset,
   fmbs_req_if  req_chan,
   fmbs_rsp_if  rsp_chan,
   fmbs_csr_if  csr_chan,
   output int   error_count,
   output int   pending_count,
   output int   result_count
);

   localparam int TOTAL_BASES  = fmbs_pkg::MAX_BASES_DEF;
   localparam int BLOCK_SIZE   = fmbs_pkg::BLOCK_BASES_DEF;
   localparam int PATTERN_CAP  = fmbs_pkg::MAX_PATTERN_DEF;
   localparam int STORE_DEPTH  = TOTAL_BASES / 4;
   localparam int CKPT_DEPTH   = TOTAL_BASES / BLOCK_SIZE + 1;
   localparam int MASK_21      = 32'h1FFFFF;

   typedef struct {
      logic [fmbs_pkg::ML_W-1:0]  match_length;
      logic [fmbs_pkg::CNT_W-1:0] range_start;
      logic [fmbs_pkg::CNT_W-1:0] range_end;
      logic [fmbs_pkg::CNT_W-1:0] final_start;
      logic [fmbs_pkg::CNT_W-1:0] final_end;
      logic                       full_match;
   } search_hit_type;

   search_hit_type expected_hits[$];
   bit [7:0]       bwt_bytes[STORE_DEPTH];
   bit [fmbs_pkg::CNT_W-1:0] block_counts[CKPT_DEPTH][4];
   int unsigned    base_totals[4];
   int unsigned    sym_offsets[5];
   int unsigned    fill_ptr, range_lo, range_hi, last_lo, last_hi, matched;
   bit             halted;
   int unsigned    text_len, sentinel_row;

   function automatic int unsigned visible_len();
      return (text_len < TOTAL_BASES) ? text_len : TOTAL_BASES;
   endfunction

   function automatic int unsigned base_of(bit [7:0] b, int unsigned j);
      return (b >> (6 - 2 * (j & 3))) & 3;
   endfunction

   function automatic int unsigned count_before(int unsigned sym, int unsigned pos);
      int unsigned blk, x;
      // The sentinel row holds no base, so positions past it shift down by one.
      if (pos > sentinel_row) pos--;
      if (pos > visible_len()) pos = visible_len();
      blk = pos / BLOCK_SIZE;
      x = block_counts[blk][sym];
      for (int unsigned b = blk * (BLOCK_SIZE / 4); b < pos / 4; b++)
         for (int unsigned j = 0; j < 4; j++)
            if (base_of(bwt_bytes[b], j) == sym) x++;
      for (int unsigned j = 0; j < pos % 4; j++)
         if (base_of(bwt_bytes[(pos / 4) % STORE_DEPTH], j) == sym) x++;
      return x & MASK_21;
   endfunction

   task automatic store_bwt_byte(bit [7:0] b, bit last);
      int unsigned len;
      len = visible_len();
      if (fill_ptr < STORE_DEPTH && fill_ptr * 4 < len) begin
         bwt_bytes[fill_ptr] = b;
         for (int unsigned j = 0; j < 4; j++)
            if (fill_ptr * 4 + j < len)
               base_totals[base_of(b, j)] = (base_totals[base_of(b, j)] + 1) & MASK_21;
         fill_ptr++;
         if (fill_ptr % (BLOCK_SIZE / 4) == 0)
            for (int s = 0; s < 4; s++)
               block_counts[fill_ptr / (BLOCK_SIZE / 4)][s] = base_totals[s];
      end
      if (last) begin
         sym_offsets[0] = 1;
         for (int s = 0; s < 4; s++)
            sym_offsets[s + 1] = (sym_offsets[s] + base_totals[s]) & MASK_21;
         fill_ptr = 0;
         base_totals = '{default: 0};
      end
   endtask

   task automatic predict_search_item(bit [1:0] sym, bit first, bit last);
      search_hit_type hit;
      int unsigned offs;
      if (first) begin
         range_lo = sym_offsets[sym];
         range_hi = sym_offsets[sym + 1];
         last_lo = 0;
         last_hi = 0;
         matched = 1;
         halted = 0;
      end else if (halted || range_hi <= range_lo) begin
         halted = 1;
      end else begin
         offs = sym_offsets[sym];
         last_lo = range_lo;
         last_hi = range_hi;
         range_lo = (offs + count_before(sym, last_lo)) & MASK_21;
         range_hi = (offs + count_before(sym, last_hi)) & MASK_21;
         if (matched < PATTERN_CAP) matched++;
      end
      if (last) begin
         if (range_hi <= range_lo) begin
            hit.match_length = (matched > 0) ? matched - 1 : 0;
            hit.range_start = last_lo;
            hit.range_end = last_hi;
            hit.full_match = 1'b0;
         end else begin
            hit.match_length = matched;
            hit.range_start = range_lo;
            hit.range_end = range_hi;
            hit.full_match = 1'b1;
         end
         hit.final_start = range_lo;
         hit.final_end = range_hi;
         expected_hits.push_back(hit);
      end
   endtask

   task automatic compare_hit();
      search_hit_type want;
      if (expected_hits.size() == 0) begin
         $error("unexpected result transaction");
         error_count++;
         return;
      end
      want = expected_hits.pop_front();
      result_count++;
      if (rsp_chan.match_length !== want.match_length) begin
         $error("match_length: expected %0d, got %0d", want.match_length,
                rsp_chan.match_length);
         error_count++;
      end
      if (rsp_chan.range_start !== want.range_start) begin
         $error("range_start: expected %0d, got %0d", want.range_start, rsp_chan.range_start);
         error_count++;
      end
      if (rsp_chan.range_end !== want.range_end) begin
         $error("range_end: expected %0d, got %0d", want.range_end, rsp_chan.range_end);
         error_count++;
      end
      if (rsp_chan.final_start !== want.final_start) begin
         $error("final_start: expected %0d, got %0d", want.final_start, rsp_chan.final_start);
         error_count++;
      end
      if (rsp_chan.final_end !== want.final_end) begin
         $error("final_end: expected %0d, got %0d", want.final_end, rsp_chan.final_end);
         error_count++;
      end
      if (rsp_chan.full_match !== want.full_match) begin
         $error("full_match: expected %0d, got %0d", want.full_match, rsp_chan.full_match);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_totals = '{default: 0};
         sym_offsets = '{default: 0};
         fill_ptr = 0;
         range_lo = 0;
         range_hi = 0;
         last_lo = 0;
         last_hi = 0;
         matched = 0;
         halted = 0;
         text_len = 1;
         sentinel_row = 0;
         error_count = 0;
         result_count = 0;
         expected_hits.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == fmbs_pkg::REG_BWT_LENGTH) text_len = csr_chan.data;
            else if (csr_chan.index == fmbs_pkg::REG_SENTINEL_POS)
               sentinel_row = csr_chan.data;
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.func == fmbs_pkg::FUNC_LOAD)
               store_bwt_byte(req_chan.packed_byte, req_chan.is_last);
            else
               predict_search_item(req_chan.symbol, req_chan.is_first, req_chan.is_last);
         end
         if (rsp_chan.valid && rsp_chan.ready) compare_hit();
      end
      pending_count = expected_hits.size();
   end

endmodule

/* bench/testbench.sv */
module testbench;

   // Indexes that select no register; writes to them must be ignored.
   localparam logic [fmbs_pkg::CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [fmbs_pkg::CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam int LONG_PATTERN = 40;

   logic clock;
   logic reset;
   int   error_count, pending_count, result_count;
   logic req_took, csr_took;
   int   burst_left;
   int   pattern_total;
   int   stall_cycle;
   bit [1:0] text_bases[$];

   fmbs_req_if req_chan();
   fmbs_rsp_if rsp_chan();
   fmbs_csr_if csr_chan();

   fm_index_backward_search u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   fmbs_search_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      req_took <= req_chan.valid && req_chan.ready;
      csr_took <= csr_chan.valid && csr_chan.ready;
   end

   // The result side switches among four stall styles in turn.
   initial stall_cycle = 0;
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case ((stall_cycle / 256) % 4)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_chan.ready <= ((stall_cycle % 7) < 3);
         default: rsp_chan.ready <= ((stall_cycle % 23) > 14);
      endcase
   end

   task automatic send_item(bit f, bit [7:0] pb, bit [1:0] sym, bit first, bit last);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_chan.valid = 1'b1;
      req_chan.func = f;
      req_chan.packed_byte = pb;
      req_chan.symbol = sym;
      req_chan.is_first = first;
      req_chan.is_last = last;
      @(negedge clock);
      while (!req_took) @(negedge clock);
      burst_left--;
   endtask

   task automatic write_reg(logic [fmbs_pkg::CSR_IDX_W-1:0] idx, int unsigned value);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data = value;
      @(negedge clock);
      while (!csr_took) @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // Registers change only once all results are in and the block has drained.
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic load_text(int unsigned len, int unsigned extra, bit all_zero);
      int unsigned nbytes;
      bit [7:0] b;
      text_bases.delete();
      nbytes = (len + 3) / 4 + extra;
      for (int unsigned i = 0; i < nbytes; i++) begin
         b = all_zero ? 8'h00 : 8'($urandom);
         for (int unsigned j = 0; j < 4; j++)
            if (i * 4 + j < len) text_bases.push_back(b[7 - 2 * j -: 2]);
         send_item(fmbs_pkg::FUNC_LOAD, b, 2'($urandom), 1'($urandom), i == nbytes - 1);
      end
   endtask

   task automatic search_pattern(int unsigned m, int unsigned mode);
      bit [1:0] syms[$];
      int unsigned p;
      p = $urandom_range(0, text_bases.size() - 1);
      for (int unsigned k = 0; k < m; k++)
         syms.push_back((mode == 2 || p + k >= text_bases.size()) ?
                        2'($urandom) : text_bases[p + k]);
      if (mode == 1) syms[$urandom_range(0, m - 1)] = 2'($urandom);
      for (int k = m - 1; k >= 0; k--)
         send_item(fmbs_pkg::FUNC_SEARCH, 8'($urandom), syms[k], k == m - 1, k == 0);
      pattern_total++;
   endtask

   task automatic run_phase(int unsigned len, int unsigned sent, int unsigned items);
      int unsigned sent_items, m, roll;
      wait_idle();
      write_reg(fmbs_pkg::REG_BWT_LENGTH, len);
      write_reg(fmbs_pkg::REG_SENTINEL_POS, sent);
      load_text(len, $urandom_range(0, 2), 1'b0);
      sent_items = 0;
      while (sent_items < items) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // Stray symbol with random markers.
            send_item(fmbs_pkg::FUNC_SEARCH, 8'($urandom), 2'($urandom), 1'($urandom),
                      1'($urandom));
            sent_items++;
         end else begin
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            search_pattern(m, roll < 20 ? 1 : (roll < 28 ? 2 : 0));
            sent_items += m;
         end
      end
   endtask

   initial begin
      int unsigned len, sent;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = fmbs_pkg::FUNC_LOAD;
      req_chan.packed_byte = '0;
      req_chan.symbol = '0;
      req_chan.is_first = 1'b0;
      req_chan.is_last = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = fmbs_pkg::REG_BWT_LENGTH;
      csr_chan.data = '0;
      burst_left = 0;
      pattern_total = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Symbols before any search has started leave the range empty.
      send_item(fmbs_pkg::FUNC_SEARCH, 8'hFF, 2'd3, 1'b0, 1'b0);
      send_item(fmbs_pkg::FUNC_SEARCH, 8'h00, 2'd1, 1'b0, 1'b1);

      // Shortest text, one base; every symbol as a single-base pattern.
      wait_idle();
      write_reg(fmbs_pkg::REG_BWT_LENGTH, 1);
      write_reg(fmbs_pkg::REG_SENTINEL_POS, 0);
      write_reg(REG_SPARE_2, 21'h1FFFFF);
      write_reg(REG_SPARE_3, 21'h0AAAAA);
      load_text(1, 1, 1'b0);
      for (int s = 0; s < 4; s++)
         send_item(fmbs_pkg::FUNC_SEARCH, 8'h00, 2'(s), 1'b1, 1'b1);
      send_item(fmbs_pkg::FUNC_SEARCH, 8'hFF, 2'd0, 1'b1, 1'b0);
      send_item(fmbs_pkg::FUNC_SEARCH, 8'h00, 2'd0, 1'b0, 1'b0);
      send_item(fmbs_pkg::FUNC_SEARCH, 8'hFF, 2'd0, 1'b0, 1'b1);

      // Register values at the base capacity; only a short load follows and no search reads it.
      wait_idle();
      write_reg(fmbs_pkg::REG_BWT_LENGTH, fmbs_pkg::MAX_BASES_DEF);
      write_reg(fmbs_pkg::REG_SENTINEL_POS, fmbs_pkg::MAX_BASES_DEF);
      for (int i = 0; i < 8; i++)
         send_item(fmbs_pkg::FUNC_LOAD, 8'($urandom), 2'd0, 1'b0, i == 7);

      // Text of one base only keeps the range full across a long pattern.
      wait_idle();
      write_reg(fmbs_pkg::REG_BWT_LENGTH, 64);
      write_reg(fmbs_pkg::REG_SENTINEL_POS, 0);
      load_text(64, 0, 1'b1);
      for (int k = LONG_PATTERN - 1; k >= 0; k--)
         send_item(fmbs_pkg::FUNC_SEARCH, 8'($urandom), 2'd0, k == LONG_PATTERN - 1, k == 0);
      pattern_total++;

      for (int ph = 0; ph < 4; ph++) begin
         len = (ph == 0) ? 17 : $urandom_range(2, 300);
         case ($urandom_range(0, 5))
            0: sent = len;
            1: sent = len + $urandom_range(1, 3);
            2: sent = fmbs_pkg::MAX_BASES_DEF;
            default: sent = $urandom_range(0, len);
         endcase
         run_phase(len, sent, 55);
      end

      wait_idle();
      $display("Checked %0d search results from %0d patterns over several texts,",
               result_count, pattern_total);
      $display("including long matches, sentinel placement and stall patterns.");
      if (error_count == 0) begin
         $display("** fm_index_backward_search: PASSED **");
      end else begin
         $display("** fm_index_backward_search: FAILED **");
      end
      $finish;
   end

   initial begin
      #(12 * 2000000);
      $display("** fm_index_backward_search: FAILED **");
      $finish;
   end

endmodule

/* fm_index_backward_search.f */
rtl/fmbs_pkg.sv
rtl/fmbs_if.sv
rtl/fmbs_ram.sv
rtl/fmbs_ctrl.sv
rtl/fmbs_dpath.sv
rtl/fm_index_backward_search.sv
bench/fmbs_search_checker.sv
bench/testbench.sv
